// ===== rtl/running_kth_largest_top_macros.svh =====
// Assertion helpers for the RTL file that carries checks.
`ifndef RUNNING_KTH_LARGEST_TOP_MACROS_SVH
`define RUNNING_KTH_LARGEST_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RKL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define RKL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rkl_pkg.sv =====
`default_nettype none

package rkl_pkg;

    // Width of a stream value and of the rank write data.
    localparam int KEY_W  = 32;
    localparam int RANK_W = 7;

    // Result value reported while fewer than k values are kept.
    localparam logic signed [KEY_W-1:0] NOT_READY_VALUE = '1;

    // Control handed from one cell to its right neighbor.
    typedef struct packed {
        logic active;   // cell holds a live entry for this transaction
        logic ins;      // new value lands at or before this cell
    } t_link;

endpackage

`default_nettype wire

// ===== rtl/rkl_if.sv =====
`default_nettype none

// Input channel: one stream value per transaction.
interface rkl_in_if;
    import rkl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] value;
    logic                    restart;

    modport source (output valid, output value, output restart, input ready);
    modport sink   (input valid, input value, input restart, output ready);
endinterface

// Output channel: one result per transaction.
interface rkl_out_if;
    import rkl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] kth_largest;
    logic                    ready_res;

    modport source (output valid, output kth_largest, output ready_res, input ready);
    modport sink   (input valid, input kth_largest, input ready_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/rkl_cell.sv =====
`default_nettype none

// One slot of the sorted chain. Entries run from largest (cell 0) to smallest.
module rkl_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_load,
    input  wire logic                            i_restart,
    input  wire logic                            i_in_range,
    input  wire logic signed [rkl_pkg::KEY_W-1:0] i_key,
    input  wire rkl_pkg::t_link                  i_left,
    input  wire logic signed [rkl_pkg::KEY_W-1:0] i_left_key,
    output rkl_pkg::t_link                       o_link,
    output logic signed [rkl_pkg::KEY_W-1:0]     o_key,
    output logic                                 o_valid
);
    import rkl_pkg::*;

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic                    n_valid;
    logic signed [KEY_W-1:0] n_key;
    logic                    active;
    logic                    ins;

    // An entry counts only while it is inside the current rank and no restart is seen.
    always_comb begin
        active = r_valid & i_in_range & ~i_restart;
        ins    = ~active | (r_key < i_key);
    end

    // Keep the entry, take the shifted neighbor, or take the new value.
    always_comb begin
        n_valid = i_in_range & (active | i_left.active);
        if (!ins) begin
            n_key = r_key;
        end else if (i_left.ins && i_left.active) begin
            n_key = i_left_key;
        end else begin
            n_key = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= n_key;
        end
    end

    assign o_link.active = active;
    assign o_link.ins    = ins;
    assign o_key         = r_key;
    assign o_valid       = r_valid;

endmodule

`default_nettype wire

// ===== rtl/running_kth_largest_top.sv =====
// Channel   Dir  Handshake            Payload
// i_in      in   valid/ready          value (s32), restart (1)
// o_out     out  valid/ready          kth_largest (s32), ready_res (1)
// i_cfg_*   in   write enable only    rank_k (7)
//
// One transaction per clock cycle when the output side keeps up.
// The chain of MAX_RANK cells registers the insertion; the result is then
// picked from cell k-1 and registered in the output stage.
// Reset clears the cell valid bits and the handshake state; rank_k is 1.
// A stalled output holds its result while one more transaction sits in the chain.
`default_nettype none
`include "running_kth_largest_top_macros.svh"

module running_kth_largest_top #(
    parameter int MAX_RANK = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [rkl_pkg::RANK_W-1:0]  i_cfg_wdata,
    rkl_in_if.sink                           i_in,
    rkl_out_if.source                        o_out
);
    import rkl_pkg::*;

    localparam int IDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    logic [IDX_W-1:0]        r_kidx;
    logic                    r_pend;
    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_out_kth;
    logic                    r_out_ready_res;
    logic                    n_pend;

    logic                    out_free;
    logic                    load;
    logic                    pick_valid;
    logic signed [KEY_W-1:0] pick_key;

    t_link                   cell_link  [MAX_RANK];
    logic signed [KEY_W-1:0] cell_key   [MAX_RANK];
    logic [MAX_RANK-1:0]     cell_valid;
    logic [MAX_RANK-1:0]     cell_sorted;

    // Rank register holds the saturated index of the reported cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kidx <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                r_kidx <= '0;
            end else if (int'(i_cfg_wdata) > MAX_RANK) begin
                r_kidx <= IDX_W'(MAX_RANK - 1);
            end else begin
                r_kidx <= IDX_W'(i_cfg_wdata - RANK_W'(1));
            end
        end
    end

    // Chain of cells; cell 0 sees a neighbor that never shifts.
    for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
        t_link                   left;
        logic signed [KEY_W-1:0] left_key;
        logic                    in_range;

        if (g == 0) begin : g_head
            assign left.active = 1'b1;
            assign left.ins    = 1'b0;
            assign left_key    = '0;
        end else begin : g_body
            assign left     = cell_link[g-1];
            assign left_key = cell_key[g-1];
        end

        assign in_range = (IDX_W'(g) <= r_kidx);

        rkl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (load),
            .i_restart  (i_in.restart),
            .i_in_range (in_range),
            .i_key      (i_in.value),
            .i_left     (left),
            .i_left_key (left_key),
            .o_link     (cell_link[g]),
            .o_key      (cell_key[g]),
            .o_valid    (cell_valid[g])
        );

        // Check term: valid entries stay in descending order.
        if (g == 0) begin : g_ord_head
            assign cell_sorted[g] = 1'b1;
        end else begin : g_ord_body
            assign cell_sorted[g] = ~cell_valid[g] | (cell_key[g-1] >= cell_key[g]);
        end
    end

    // Handshake: the chain takes a transaction while none is pending or its last result can move on.
    always_comb begin
        out_free   = ~r_out_valid | o_out.ready;
        i_in.ready = ~r_pend | out_free;
        load       = i_in.valid & i_in.ready;
        if (load) begin
            n_pend = 1'b1;
        end else if (out_free) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // Result pick from the cell at the current rank.
    always_comb begin
        pick_valid = cell_valid[r_kidx];
        pick_key   = cell_key[r_kidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_out_kth       <= pick_valid ? pick_key : NOT_READY_VALUE;
            r_out_ready_res <= pick_valid;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kth_largest = r_out_kth;
    assign o_out.ready_res   = r_out_ready_res;

    // Checks on the chain and the result stage.
    `RKL_ASSERT_ALWAYS(a_valid_prefix, ((cell_valid & (cell_valid + 1'b1)) == '0),
        "cell valid bits do not form a prefix")
    `RKL_ASSERT_ALWAYS(a_sorted, (&cell_sorted), "kept entries out of descending order")
    `RKL_ASSERT_NEXT(a_load_pends, load, r_pend, "accepted transaction did not reach the chain")
    `RKL_ASSERT_ALWAYS(a_not_ready_value,
        (!o_out.valid || o_out.ready_res || o_out.kth_largest == NOT_READY_VALUE),
        "result without enough values is not all ones")

endmodule

`default_nettype wire
